@@ sv/assert_macros.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define VFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define VFT_ASSERT_NEXT(label, trig, cond, msg) \
    `VFT_ASSERT(label, (trig) |=> (cond), msg)

`endif

@@ sv/vft_pkg.sv @@
// Shared types, constants and functions of the frame vote tracker.
package vft_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'hB3;
    localparam logic [7:0] HDR_SECOND  = 8'hB4;
    localparam logic [7:0] TRAILER     = 8'hB6;
    localparam logic [7:0] SHAPE_CIRCLE_CODE = 8'hB1;
    localparam logic [7:0] SHAPE_RECT_CODE   = 8'hB2;
    localparam logic [7:0] SHAPE_TRI_CODE    = 8'hB7;

    localparam int NUM_CLASSES = 3;
    localparam int VOTE_W      = 9;
    localparam logic [VOTE_W-1:0] VOTE_MAX = '1;
    localparam logic [7:0] COUNTER_MAX = 8'hFF;

    localparam logic signed [7:0] ANGLE_MAX = 8'sd90;
    localparam logic signed [7:0] ANGLE_MIN = -8'sd90;
    localparam logic [7:0] COMPARE_MID = 8'd150;
    localparam logic [7:0] COMPARE_LOW = 8'd50;
    localparam logic [7:0] COMPARE_HIGH = 8'd250;
    // ceil(2^15 / 9): exact floor for dividends below about 2900
    localparam int RECIP_SHIFT = 15;
    localparam logic [23:0] RECIP_9 = 24'd3641;

    typedef logic [1:0] class_t;
    localparam class_t CLASS_NONE      = 2'd0;
    localparam class_t CLASS_FIRST     = 2'd1;
    localparam class_t CLASS_SECOND    = 2'd2;
    localparam class_t CLASS_THIRD     = 2'd3;
    localparam class_t BALL_BASKETBALL = 2'd1;

    typedef enum logic [2:0] {
        CFG_TRACKING_ENABLE  = 3'd0,
        CFG_SHAPE_VOTE_LIMIT = 3'd1,
        CFG_BALL_VOTE_LIMIT  = 3'd2,
        CFG_TRACK_INTERVAL   = 3'd3,
        CFG_CENTER_X         = 3'd4,
        CFG_LIMIT_X          = 3'd5,
        CFG_CENTER_Y         = 3'd6,
        CFG_LIMIT_Y          = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        POS_HDR_FIRST  = 3'd0,
        POS_HDR_SECOND = 3'd1,
        POS_SHAPE      = 3'd2,
        POS_X          = 3'd3,
        POS_Y          = 3'd4,
        POS_BALL       = 3'd5,
        POS_SPARE      = 3'd6,
        POS_TRAILER    = 3'd7
    } parse_pos_t;

    typedef struct packed {
        logic       tracking_enable;
        logic [7:0] shape_vote_limit;
        logic [7:0] ball_vote_limit;
        logic [7:0] track_interval;
        logic [7:0] center_x;
        logic [7:0] limit_x;
        logic [7:0] center_y;
        logic [7:0] limit_y;
    } cfg_t;

    typedef struct packed {
        logic       ok;
        logic       dropped;
        logic [7:0] shape_code;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] ball_code;
    } frame_t;

    typedef struct packed {
        logic   hit;
        class_t cls;
    } vote_t;

    typedef struct packed {
        logic       frame_ok;
        logic       frame_dropped;
        class_t     shape_class;
        class_t     ball_class;
        logic [7:0] pan_compare;
        logic [7:0] tilt_compare;
    } result_t;

    function automatic class_t shape_to_class(input logic [7:0] code);
        class_t cls;
        priority if (code == SHAPE_CIRCLE_CODE) cls = CLASS_FIRST;
        else if (code == SHAPE_RECT_CODE)       cls = CLASS_SECOND;
        else if (code == SHAPE_TRI_CODE)        cls = CLASS_THIRD;
        else                                    cls = CLASS_NONE;
        return cls;
    endfunction

    function automatic class_t ball_to_class(input logic [7:0] code);
        class_t cls;
        if (code >= 8'(CLASS_FIRST) && code <= 8'(CLASS_THIRD))
            cls = code[1:0];
        else
            cls = CLASS_NONE;
        return cls;
    endfunction

    // 150 + floor(10*angle/9), negative side rounds toward minus infinity
    function automatic logic [7:0] angle_to_compare(input logic signed [7:0] angle);
        logic [7:0]  mag;
        logic [10:0] scaled;
        logic [23:0] prod;
        logic [7:0]  quot;
        mag    = angle[7] ? (~angle + 8'd1) : angle;
        scaled = 11'(mag) * 11'd10;
        if (angle[7])
            scaled = scaled + 11'd8;
        prod = 24'(scaled) * RECIP_9;
        quot = prod[RECIP_SHIFT +: 8];
        return angle[7] ? (COMPARE_MID - quot) : (COMPARE_MID + quot);
    endfunction

endpackage

@@ sv/vft_rx_if.sv @@
// Input byte channel of the frame vote tracker.
interface vft_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ sv/vft_status_if.sv @@
// Result channel of the frame vote tracker.
interface vft_status_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic       frame_dropped;
    logic [1:0] shape_class;
    logic [1:0] ball_class;
    logic [7:0] pan_compare;
    logic [7:0] tilt_compare;

    modport source (output valid, output frame_ok, output frame_dropped,
                    output shape_class, output ball_class,
                    output pan_compare, output tilt_compare, input ready);
    modport sink (input valid, input frame_ok, input frame_dropped,
                  input shape_class, input ball_class,
                  input pan_compare, input tilt_compare, output ready);
endinterface

@@ sv/vision_frame_vote_tracker_core.sv @@
// Top level of the camera frame parser with vote counting and pan/tilt tracking.
//
// Channels: rx carries one camera link byte per transaction; status returns one
// result per accepted byte (frame_ok, frame_dropped, shape_class, ball_class,
// pan_compare, tilt_compare). Configuration is written through cfg_we,
// cfg_index and cfg_data, one register per cycle, while no byte is in flight.
// Path: a byte accepted on rx is held in the input register; its result is
// loaded into the result register when the byte advances, which raises status.valid.
// Throughput: one byte per cycle; all per-byte work (parse, vote compare,
// angle step, compare scaling) sits between the input and result registers.
// When status is stalled, the result register holds, the input register keeps
// one more byte, and rx.ready drops once both are full.
// Reset: parser waits for the first header byte, votes and angles are zero,
// shape class none, ball class basketball, registers take their reset values.
`include "assert_macros.svh"

module vision_frame_vote_tracker_core (
    input  logic                clk,
    input  logic                rst_n,
    vft_rx_if.sink              rx,
    vft_status_if.source        status,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    vft_pkg::cfg_t    cfg_reg;
    logic [7:0]       byte_reg;
    logic             byte_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             good_step;
    vft_pkg::frame_t  frame;
    vft_pkg::vote_t   shape_vote;
    vft_pkg::vote_t   ball_vote;
    vft_pkg::class_t  shape_class_reg, shape_class_next;
    vft_pkg::class_t  ball_class_reg, ball_class_next;
    logic [7:0]       pan_cmp;
    logic [7:0]       tilt_cmp;
    vft_pkg::result_t res_reg, res_next;

    assign advance   = byte_valid_reg && (!out_valid_reg || status.ready);
    assign rx.ready  = !byte_valid_reg || advance;
    assign good_step = advance && frame.ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tracking_enable  <= 1'b0;
            cfg_reg.shape_vote_limit <= 8'd50;
            cfg_reg.ball_vote_limit  <= 8'd1;
            cfg_reg.track_interval   <= 8'd5;
            cfg_reg.center_x         <= 8'd75;
            cfg_reg.limit_x          <= 8'd200;
            cfg_reg.center_y         <= 8'd67;
            cfg_reg.limit_y          <= 8'd100;
        end
        else if (cfg_we)
        begin
            unique case (vft_pkg::cfg_idx_t'(cfg_index))
                vft_pkg::CFG_TRACKING_ENABLE:  cfg_reg.tracking_enable  <= cfg_data[0];
                vft_pkg::CFG_SHAPE_VOTE_LIMIT: cfg_reg.shape_vote_limit <= cfg_data;
                vft_pkg::CFG_BALL_VOTE_LIMIT:  cfg_reg.ball_vote_limit  <= cfg_data;
                vft_pkg::CFG_TRACK_INTERVAL:   cfg_reg.track_interval   <= cfg_data;
                vft_pkg::CFG_CENTER_X:         cfg_reg.center_x         <= cfg_data;
                vft_pkg::CFG_LIMIT_X:          cfg_reg.limit_x          <= cfg_data;
                vft_pkg::CFG_CENTER_Y:         cfg_reg.center_y         <= cfg_data;
                vft_pkg::CFG_LIMIT_Y:          cfg_reg.limit_y          <= cfg_data;
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (rx.ready)
            byte_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            byte_reg <= rx.rx_byte;
    end

    vft_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .frame   (frame)
    );

    vft_vote u_shape_vote (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (good_step),
        .code  (vft_pkg::shape_to_class(frame.shape_code)),
        .limit (cfg_reg.shape_vote_limit),
        .vote  (shape_vote)
    );

    vft_vote u_ball_vote (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (good_step),
        .code  (vft_pkg::ball_to_class(frame.ball_code)),
        .limit (cfg_reg.ball_vote_limit),
        .vote  (ball_vote)
    );

    vft_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (good_step),
        .cfg          (cfg_reg),
        .x            (frame.x),
        .y            (frame.y),
        .pan_compare  (pan_cmp),
        .tilt_compare (tilt_cmp)
    );

    assign shape_class_next = shape_vote.hit ? shape_vote.cls : shape_class_reg;
    assign ball_class_next  = ball_vote.hit ? ball_vote.cls : ball_class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_class_reg <= vft_pkg::CLASS_NONE;
            ball_class_reg  <= vft_pkg::BALL_BASKETBALL;
        end
        else if (advance)
        begin
            shape_class_reg <= shape_class_next;
            ball_class_reg  <= ball_class_next;
        end
    end

    // result stage
    always_comb
    begin
        res_next.frame_ok      = frame.ok;
        res_next.frame_dropped = frame.dropped;
        res_next.shape_class   = shape_class_next;
        res_next.ball_class    = ball_class_next;
        res_next.pan_compare   = pan_cmp;
        res_next.tilt_compare  = tilt_cmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (status.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign status.valid         = out_valid_reg;
    assign status.frame_ok      = res_reg.frame_ok;
    assign status.frame_dropped = res_reg.frame_dropped;
    assign status.shape_class   = res_reg.shape_class;
    assign status.ball_class    = res_reg.ball_class;
    assign status.pan_compare   = res_reg.pan_compare;
    assign status.tilt_compare  = res_reg.tilt_compare;

    `VFT_ASSERT(a_ok_not_dropped, out_valid_reg |-> !(res_reg.frame_ok && res_reg.frame_dropped), "frame both completed and dropped")
    `VFT_ASSERT_NEXT(a_advance_loads, advance, out_valid_reg, "processed byte produced no result")
    `VFT_ASSERT_NEXT(a_byte_kept, byte_valid_reg && !advance, byte_valid_reg, "held byte lost")
    `VFT_ASSERT(a_pan_range, out_valid_reg |-> (res_reg.pan_compare >= vft_pkg::COMPARE_LOW && res_reg.pan_compare <= vft_pkg::COMPARE_HIGH), "pan compare out of range")
    `VFT_ASSERT(a_tilt_range, out_valid_reg |-> (res_reg.tilt_compare >= vft_pkg::COMPARE_LOW && res_reg.tilt_compare <= vft_pkg::COMPARE_HIGH), "tilt compare out of range")

endmodule

@@ sv/vft_parse.sv @@
// Frame parser: header, field capture and trailer check.
module vft_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      rx_byte,
    output vft_pkg::frame_t frame
);

    vft_pkg::parse_pos_t pos_reg, pos_next;
    logic [7:0] shape_reg, shape_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] ball_reg, ball_next;
    logic       ok_c;
    logic       drop_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= vft_pkg::POS_HDR_FIRST;
            shape_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            ball_reg  <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            shape_reg <= shape_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            ball_reg  <= ball_next;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        shape_next = shape_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ball_next  = ball_reg;
        ok_c       = 1'b0;
        drop_c     = 1'b0;
        unique case (pos_reg)
            vft_pkg::POS_HDR_FIRST:
            begin
                if (rx_byte == vft_pkg::HDR_FIRST)
                    pos_next = vft_pkg::POS_HDR_SECOND;
                else
                    drop_c = 1'b1;
            end
            vft_pkg::POS_HDR_SECOND:
            begin
                if (rx_byte == vft_pkg::HDR_SECOND)
                    pos_next = vft_pkg::POS_SHAPE;
                else
                begin
                    pos_next = vft_pkg::POS_HDR_FIRST;
                    drop_c   = 1'b1;
                end
            end
            vft_pkg::POS_SHAPE:
            begin
                shape_next = rx_byte;
                pos_next   = vft_pkg::POS_X;
            end
            vft_pkg::POS_X:
            begin
                x_next   = rx_byte;
                pos_next = vft_pkg::POS_Y;
            end
            vft_pkg::POS_Y:
            begin
                y_next   = rx_byte;
                pos_next = vft_pkg::POS_BALL;
            end
            vft_pkg::POS_BALL:
            begin
                ball_next = rx_byte;
                pos_next  = vft_pkg::POS_SPARE;
            end
            vft_pkg::POS_SPARE:
            begin
                pos_next = vft_pkg::POS_TRAILER;
            end
            vft_pkg::POS_TRAILER:
            begin
                pos_next = vft_pkg::POS_HDR_FIRST;
                if (rx_byte == vft_pkg::TRAILER)
                    ok_c = 1'b1;
                else
                    drop_c = 1'b1;
            end
            default:
            begin
                pos_next = vft_pkg::POS_HDR_FIRST;
            end
        endcase
        if (drop_c)
        begin
            shape_next = '0;
            x_next     = '0;
            y_next     = '0;
            ball_next  = '0;
        end
    end

    // a good trailer leaves the captured fields untouched; a bad one clears them
    assign frame.ok         = ok_c;
    assign frame.dropped    = drop_c;
    assign frame.shape_code = shape_reg;
    assign frame.x          = x_reg;
    assign frame.y          = y_reg;
    assign frame.ball_code  = ball_reg;

endmodule

@@ sv/vft_vote.sv @@
// Vote counters for one group of three classes with limit check.
module vft_vote (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  vft_pkg::class_t code,
    input  logic [7:0]      limit,
    output vft_pkg::vote_t  vote
);

    logic [vft_pkg::VOTE_W-1:0] cnt_reg [vft_pkg::NUM_CLASSES];
    logic [vft_pkg::VOTE_W-1:0] cnt_inc [vft_pkg::NUM_CLASSES];
    logic [vft_pkg::VOTE_W-1:0] cnt_next [vft_pkg::NUM_CLASSES];
    vft_pkg::vote_t vote_c;

    always_comb
    begin
        for (int k = 0; k < vft_pkg::NUM_CLASSES; k++)
        begin
            cnt_inc[k] = cnt_reg[k];
            if (code == vft_pkg::class_t'(k + 1) && cnt_reg[k] != vft_pkg::VOTE_MAX)
                cnt_inc[k] = cnt_reg[k] + 1'b1;
        end
        vote_c = '0;
        // lowest class over the limit wins
        for (int k = vft_pkg::NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (cnt_inc[k] > vft_pkg::VOTE_W'(limit))
            begin
                vote_c.hit = 1'b1;
                vote_c.cls = vft_pkg::class_t'(k + 1);
            end
        end
        for (int k = 0; k < vft_pkg::NUM_CLASSES; k++)
            cnt_next[k] = vote_c.hit ? '0 : cnt_inc[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < vft_pkg::NUM_CLASSES; k++)
                cnt_reg[k] <= '0;
        end
        else if (step)
        begin
            for (int k = 0; k < vft_pkg::NUM_CLASSES; k++)
                cnt_reg[k] <= cnt_next[k];
        end
    end

    assign vote = step ? vote_c : '0;

endmodule

@@ sv/vft_track.sv @@
// Pan and tilt stepping, frame counter and servo compare values.
module vft_track (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  vft_pkg::cfg_t cfg,
    input  logic [7:0]    x,
    input  logic [7:0]    y,
    output logic [7:0]    pan_compare,
    output logic [7:0]    tilt_compare
);

    logic signed [7:0] pan_reg, pan_next;
    logic signed [7:0] tilt_reg, tilt_next;
    logic [7:0]        count_reg, count_next;
    logic [7:0]        count_base;
    logic              due;

    always_comb
    begin
        due       = (count_reg > cfg.track_interval) && cfg.tracking_enable;
        pan_next  = pan_reg;
        tilt_next = tilt_reg;
        if (due)
        begin
            if (x < cfg.center_x && x != 8'd0)
            begin
                if (pan_reg < vft_pkg::ANGLE_MAX)
                    pan_next = pan_reg + 8'sd1;
            end
            else if (x > cfg.center_x && x < cfg.limit_x)
            begin
                if (pan_reg > vft_pkg::ANGLE_MIN)
                    pan_next = pan_reg - 8'sd1;
            end
            if (y < cfg.center_y && y != 8'd0)
            begin
                if (tilt_reg > vft_pkg::ANGLE_MIN)
                    tilt_next = tilt_reg - 8'sd1;
            end
            else if (y > cfg.center_y && y < cfg.limit_y)
            begin
                if (tilt_reg < vft_pkg::ANGLE_MAX)
                    tilt_next = tilt_reg + 8'sd1;
            end
        end
        count_base = due ? 8'd0 : count_reg;
        count_next = (count_base < vft_pkg::COUNTER_MAX) ? count_base + 8'd1 : count_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_reg   <= '0;
            tilt_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            pan_reg   <= pan_next;
            tilt_reg  <= tilt_next;
            count_reg <= count_next;
        end
    end

    assign pan_compare  = vft_pkg::angle_to_compare(step ? pan_next : pan_reg);
    assign tilt_compare = vft_pkg::angle_to_compare(step ? tilt_next : tilt_reg);

endmodule

@@ test/tb_vision_frame_vote_tracker_core.sv @@
// Self-checking testbench for the camera frame parser, vote counter and pan/tilt tracker.
`timescale 1ns / 1ps

module tb_vision_frame_vote_tracker_core;

    typedef enum logic [1:0] {AIM_ANY, AIM_UP, AIM_DOWN} aim_t;

    typedef struct {
        logic [7:0]       rx;
        bit               typed;
        vft_pkg::result_t want;
    } dir_row_t;

    localparam int ANGLE_LIM = int'(vft_pkg::ANGLE_MAX);
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_LIMIT = 5000;

    localparam vft_pkg::result_t DROP_AT_RESET =
        '{1'b0, 1'b1, vft_pkg::CLASS_NONE, vft_pkg::BALL_BASKETBALL,
          vft_pkg::COMPARE_MID, vft_pkg::COMPARE_MID};
    localparam vft_pkg::result_t WAIT_AT_RESET =
        '{1'b0, 1'b0, vft_pkg::CLASS_NONE, vft_pkg::BALL_BASKETBALL,
          vft_pkg::COMPARE_MID, vft_pkg::COMPARE_MID};

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    vft_rx_if     rx_ch();
    vft_status_if status_ch();

    vision_frame_vote_tracker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .status    (status_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tracker shadow state
    vft_pkg::cfg_t       tb_cfg;
    vft_pkg::parse_pos_t parse_pos;
    logic [7:0]          f_shape, f_x, f_y, f_ball;
    logic [2:0][8:0]     shape_votes, ball_votes;
    vft_pkg::class_t     shape_now, ball_now;
    int                  pan_deg, tilt_deg;
    logic [7:0]          frames_seen;

    vft_pkg::result_t pending_status[$];

    int  fault_count = 0;
    int  bytes_sent = 0;
    int  settings_written = 0;
    int  good_frames = 0;
    int  drops = 0;
    logic [7:0] pan_lo = 8'hFF, pan_hi = 8'h00, tilt_lo = 8'hFF, tilt_hi = 8'h00;
    bit  no_idle = 1'b0;
    bit  hold_armed = 1'b0;

    dir_row_t dir_rows [0:26] = '{
        '{8'h00, 1'b1, DROP_AT_RESET},
        '{vft_pkg::HDR_FIRST, 1'b1, WAIT_AT_RESET},
        '{8'h55, 1'b1, DROP_AT_RESET},
        '{vft_pkg::HDR_FIRST, 1'b0, '0}, '{vft_pkg::HDR_SECOND, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h0A, 1'b0, '0}, '{8'h0A, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{vft_pkg::TRAILER, 1'b0, '0},
        '{vft_pkg::HDR_FIRST, 1'b0, '0}, '{vft_pkg::HDR_SECOND, 1'b0, '0},
        '{vft_pkg::SHAPE_RECT_CODE, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{vft_pkg::TRAILER, 1'b0, '0},
        '{vft_pkg::HDR_FIRST, 1'b0, '0}, '{vft_pkg::HDR_SECOND, 1'b0, '0},
        '{vft_pkg::SHAPE_TRI_CODE, 1'b0, '0},
        '{8'h01, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h03, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'hB5, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("DONE: errors detected");
        $finish;
    end

    // 150 + floor(10*angle/9)
    function automatic logic [7:0] servo_compare(input int deg);
        int q;
        if (deg >= 0)
            q = (10 * deg) / 9;
        else
            q = -((-10 * deg + 8) / 9);
        return 8'(int'(vft_pkg::COMPARE_MID) + q);
    endfunction

    // lowest code over the limit wins and clears the group
    function automatic vft_pkg::class_t tally(inout logic [2:0][8:0] votes,
                                              input vft_pkg::class_t code,
                                              input logic [7:0] lim);
        if (code != vft_pkg::CLASS_NONE && votes[int'(code) - 1] != vft_pkg::VOTE_MAX)
            votes[int'(code) - 1] = votes[int'(code) - 1] + 9'd1;
        for (int k = 0; k < vft_pkg::NUM_CLASSES; k++)
        begin
            if (votes[k] > 9'(lim))
            begin
                votes = '0;
                return vft_pkg::class_t'(k + 1);
            end
        end
        return vft_pkg::CLASS_NONE;
    endfunction

    function automatic vft_pkg::result_t next_status(input logic [7:0] b);
        vft_pkg::result_t r;
        vft_pkg::class_t  cls;
        vft_pkg::class_t  hit;
        r = '0;
        case (parse_pos)
            vft_pkg::POS_HDR_FIRST:
                if (b == vft_pkg::HDR_FIRST)
                    parse_pos = vft_pkg::POS_HDR_SECOND;
                else
                begin
                    {f_shape, f_x, f_y, f_ball} = '0;
                    r.frame_dropped = 1'b1;
                end
            vft_pkg::POS_HDR_SECOND:
                if (b == vft_pkg::HDR_SECOND)
                    parse_pos = vft_pkg::POS_SHAPE;
                else
                begin
                    parse_pos = vft_pkg::POS_HDR_FIRST;
                    {f_shape, f_x, f_y, f_ball} = '0;
                    r.frame_dropped = 1'b1;
                end
            vft_pkg::POS_SHAPE:
            begin
                f_shape = b;
                parse_pos = vft_pkg::POS_X;
            end
            vft_pkg::POS_X:
            begin
                f_x = b;
                parse_pos = vft_pkg::POS_Y;
            end
            vft_pkg::POS_Y:
            begin
                f_y = b;
                parse_pos = vft_pkg::POS_BALL;
            end
            vft_pkg::POS_BALL:
            begin
                f_ball = b;
                parse_pos = vft_pkg::POS_SPARE;
            end
            vft_pkg::POS_SPARE:
                parse_pos = vft_pkg::POS_TRAILER;
            default:
            begin
                parse_pos = vft_pkg::POS_HDR_FIRST;
                if (b == vft_pkg::TRAILER)
                begin
                    r.frame_ok = 1'b1;
                    cls = (f_ball >= 8'd1 && f_ball <= 8'd3) ? vft_pkg::class_t'(f_ball[1:0])
                                                             : vft_pkg::CLASS_NONE;
                    hit = tally(ball_votes, cls, tb_cfg.ball_vote_limit);
                    if (hit != vft_pkg::CLASS_NONE)
                        ball_now = hit;
                    case (f_shape)
                        vft_pkg::SHAPE_CIRCLE_CODE: cls = vft_pkg::CLASS_FIRST;
                        vft_pkg::SHAPE_RECT_CODE:   cls = vft_pkg::CLASS_SECOND;
                        vft_pkg::SHAPE_TRI_CODE:    cls = vft_pkg::CLASS_THIRD;
                        default:                    cls = vft_pkg::CLASS_NONE;
                    endcase
                    hit = tally(shape_votes, cls, tb_cfg.shape_vote_limit);
                    if (hit != vft_pkg::CLASS_NONE)
                        shape_now = hit;
                    if (tb_cfg.tracking_enable && frames_seen > tb_cfg.track_interval)
                    begin
                        if (f_x < tb_cfg.center_x && f_x != 8'd0)
                        begin
                            if (pan_deg < ANGLE_LIM)
                                pan_deg++;
                        end
                        else if (f_x > tb_cfg.center_x && f_x < tb_cfg.limit_x)
                        begin
                            if (pan_deg > -ANGLE_LIM)
                                pan_deg--;
                        end
                        if (f_y < tb_cfg.center_y && f_y != 8'd0)
                        begin
                            if (tilt_deg > -ANGLE_LIM)
                                tilt_deg--;
                        end
                        else if (f_y > tb_cfg.center_y && f_y < tb_cfg.limit_y)
                        begin
                            if (tilt_deg < ANGLE_LIM)
                                tilt_deg++;
                        end
                        frames_seen = 8'd0;
                    end
                    if (frames_seen != vft_pkg::COUNTER_MAX)
                        frames_seen = frames_seen + 8'd1;
                end
                else
                begin
                    {f_shape, f_x, f_y, f_ball} = '0;
                    r.frame_dropped = 1'b1;
                end
            end
        endcase
        r.shape_class  = shape_now;
        r.ball_class   = ball_now;
        r.pan_compare  = servo_compare(pan_deg);
        r.tilt_compare = servo_compare(tilt_deg);
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input vft_pkg::result_t typed_want);
        vft_pkg::result_t want;
        while (!no_idle && $urandom_range(0, 99) < 31)
        begin
            rx_ch.valid = 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        want = next_status(b);
        if (typed)
            want = typed_want;
        pending_status.push_back(want);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] coord_near(input logic [7:0] c, input logic [7:0] l);
        case ($urandom_range(0, 6))
            0: return 8'd0;
            1: return c;
            2: return c - 8'd1;
            3: return c + 8'd1;
            4: return l;
            5: return l - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input aim_t aim, input bit clean);
        logic [7:0] fb [8];
        int n;
        int len;
        fb[0] = vft_pkg::HDR_FIRST;
        fb[1] = vft_pkg::HDR_SECOND;
        case ($urandom_range(0, 3))
            0: fb[2] = vft_pkg::SHAPE_CIRCLE_CODE;
            1: fb[2] = vft_pkg::SHAPE_RECT_CODE;
            2: fb[2] = vft_pkg::SHAPE_TRI_CODE;
            default: fb[2] = 8'($urandom_range(0, 255));
        endcase
        fb[3] = coord_near(tb_cfg.center_x, tb_cfg.limit_x);
        fb[4] = coord_near(tb_cfg.center_y, tb_cfg.limit_y);
        if (aim == AIM_UP)
        begin
            if (tb_cfg.center_x >= 8'd2)
                fb[3] = 8'($urandom_range(1, int'(tb_cfg.center_x) - 1));
            if (int'(tb_cfg.limit_y) >= int'(tb_cfg.center_y) + 2)
                fb[4] = 8'($urandom_range(int'(tb_cfg.center_y) + 1,
                                          int'(tb_cfg.limit_y) - 1));
        end
        else if (aim == AIM_DOWN)
        begin
            if (int'(tb_cfg.limit_x) >= int'(tb_cfg.center_x) + 2)
                fb[3] = 8'($urandom_range(int'(tb_cfg.center_x) + 1,
                                          int'(tb_cfg.limit_x) - 1));
            if (tb_cfg.center_y >= 8'd2)
                fb[4] = 8'($urandom_range(1, int'(tb_cfg.center_y) - 1));
        end
        n = $urandom_range(0, 4);
        fb[5] = (n < 3) ? 8'(n + 1) : ((n == 3) ? 8'h00 : 8'($urandom_range(0, 255)));
        fb[6] = 8'($urandom_range(0, 255));
        fb[7] = vft_pkg::TRAILER;
        len = 8;
        if (!clean)
        begin
            if ($urandom_range(0, 11) == 0)
                fb[7] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0)
                fb[0] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0)
                fb[1] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(1, 7);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        for (int i = 0; i < len; i++)
            send_byte(fb[i], 1'b0, '0);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        rx_ch.valid = 1'b0;
        while (pending_status.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input vft_pkg::cfg_idx_t idx, input logic [7:0] v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        case (idx)
            vft_pkg::CFG_TRACKING_ENABLE:  tb_cfg.tracking_enable  = v[0];
            vft_pkg::CFG_SHAPE_VOTE_LIMIT: tb_cfg.shape_vote_limit = v;
            vft_pkg::CFG_BALL_VOTE_LIMIT:  tb_cfg.ball_vote_limit  = v;
            vft_pkg::CFG_TRACK_INTERVAL:   tb_cfg.track_interval   = v;
            vft_pkg::CFG_CENTER_X:         tb_cfg.center_x         = v;
            vft_pkg::CFG_LIMIT_X:          tb_cfg.limit_x          = v;
            vft_pkg::CFG_CENTER_Y:         tb_cfg.center_y         = v;
            default:                       tb_cfg.limit_y          = v;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(input vft_pkg::cfg_t s);
        settle();
        write_reg(vft_pkg::CFG_TRACKING_ENABLE, {7'd0, s.tracking_enable});
        write_reg(vft_pkg::CFG_SHAPE_VOTE_LIMIT, s.shape_vote_limit);
        write_reg(vft_pkg::CFG_BALL_VOTE_LIMIT, s.ball_vote_limit);
        write_reg(vft_pkg::CFG_TRACK_INTERVAL, s.track_interval);
        write_reg(vft_pkg::CFG_CENTER_X, s.center_x);
        write_reg(vft_pkg::CFG_LIMIT_X, s.limit_x);
        write_reg(vft_pkg::CFG_CENTER_Y, s.center_y);
        write_reg(vft_pkg::CFG_LIMIT_Y, s.limit_y);
        cfg_we = 1'b0;
        settings_written++;
    endtask

    function automatic logic [7:0] pick_setting();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // result side: random stalls plus one long hold-off
    initial
    begin : status_sink
        int hold_left;
        hold_left = 0;
        status_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed)
            begin
                hold_left  = HOLD_CYCLES;
                hold_armed = 1'b0;
            end
            if (hold_left > 0)
            begin
                status_ch.ready = 1'b0;
                hold_left--;
            end
            else
                status_ch.ready = (no_idle || $urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge clk)
    begin : status_check
        vft_pkg::result_t got;
        vft_pkg::result_t want;
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            got = '{status_ch.frame_ok, status_ch.frame_dropped, status_ch.shape_class,
                    status_ch.ball_class, status_ch.pan_compare, status_ch.tilt_compare};
            if (got.frame_ok)
                good_frames++;
            if (got.frame_dropped)
                drops++;
            if (got.pan_compare < pan_lo) pan_lo = got.pan_compare;
            if (got.pan_compare > pan_hi) pan_hi = got.pan_compare;
            if (got.tilt_compare < tilt_lo) tilt_lo = got.tilt_compare;
            if (got.tilt_compare > tilt_hi) tilt_hi = got.tilt_compare;
            if (pending_status.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: unexpected status transaction ok=%0d drop=%0d shape=%0d "
                             , $time, got.frame_ok, got.frame_dropped, got.shape_class,
                             "ball=%0d pan=%0d tilt=%0d", got.ball_class,
                             got.pan_compare, got.tilt_compare);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got !== want)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("%0t: status mismatch", $time);
                        $display("  expected ok=%0d drop=%0d shape=%0d ball=%0d pan=%0d tilt=%0d",
                                 want.frame_ok, want.frame_dropped, want.shape_class,
                                 want.ball_class, want.pan_compare, want.tilt_compare);
                        $display("  actual   ok=%0d drop=%0d shape=%0d ball=%0d pan=%0d tilt=%0d",
                                 got.frame_ok, got.frame_dropped, got.shape_class,
                                 got.ball_class, got.pan_compare, got.tilt_compare);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        vft_pkg::cfg_t s;
        int            start;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'd0;
        cfg_we        = 1'b0;
        cfg_index     = 3'd0;
        cfg_data      = 8'd0;
        tb_cfg        = '{1'b0, 8'd50, 8'd1, 8'd5, 8'd75, 8'd200, 8'd67, 8'd100};
        parse_pos     = vft_pkg::POS_HDR_FIRST;
        {f_shape, f_x, f_y, f_ball} = '0;
        shape_votes   = '0;
        ball_votes    = '0;
        shape_now     = vft_pkg::CLASS_NONE;
        ball_now      = vft_pkg::BALL_BASKETBALL;
        pan_deg       = 0;
        tilt_deg      = 0;
        frames_seen   = 8'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

        // step both angles up, then back down, one step per frame
        apply_settings('{1'b1, 8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd128, 8'd255});
        no_idle = 1'b1;
        repeat (12) send_frame(AIM_UP, 1'b1);
        no_idle = 1'b0;
        repeat (8) send_frame(AIM_DOWN, 1'b1);

        // tracking off; result side held off once while bytes keep coming
        s = '{1'b0, 8'd255, 8'd255, 8'd254, pick_setting(), pick_setting(),
              pick_setting(), pick_setting()};
        apply_settings(s);
        hold_armed = 1'b1;
        repeat (8) send_frame(AIM_ANY, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 0)
                s = '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
            else if (ph == 1)
                s = '{1'b1, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255};
            else
            begin
                s.tracking_enable  = 1'($urandom_range(0, 1));
                s.shape_vote_limit = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                                 : pick_setting();
                s.ball_vote_limit  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                                 : pick_setting();
                s.track_interval   = pick_setting();
                if (s.track_interval == 8'hFF)
                    s.track_interval = 8'd254;
                s.center_x = pick_setting();
                s.limit_x  = pick_setting();
                s.center_y = pick_setting();
                s.limit_y  = pick_setting();
            end
            apply_settings(s);
            start = bytes_sent;
            while (bytes_sent - start < 24)
                send_frame(AIM_ANY, 1'b0);
        end

        settle();
        if (pending_status.size() != 0)
        begin
            fault_count += pending_status.size();
            $display("%0d status transactions never arrived", pending_status.size());
        end
        $display("Sent %0d bytes under %0d register settings: %0d good frames, %0d dropped.",
                 bytes_sent, settings_written + 1, good_frames, drops);
        $display("Pan compare spanned %0d..%0d, tilt compare %0d..%0d.",
                 pan_lo, pan_hi, tilt_lo, tilt_hi);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
